>>> design/iglu_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the integer gcd / lcm unit.
// No dependencies; imported by the add/subtract unit and by the top level.
package iglu_pkg;

	localparam int W  = 64;
	localparam int CW = $clog2(W);

	typedef logic [W-1:0]  word_t;
	typedef logic [CW-1:0] cnt_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_NEGA,
		S_NEGB,
		S_INIT,
		S_TWOS,
		S_LOOP,
		S_FIN,
		S_DIV,
		S_QNEG,
		S_MUL
	} state_t;

	typedef struct packed {
		word_t opa;
		word_t opb;
		logic  sub;
	} alu_req_t;

	typedef struct packed {
		word_t sum;
		logic  borrow;
	} alu_rsp_t;

endpackage

>>> design/iglu_alu.sv
`timescale 1ns / 1ps
// Shared 64-bit add/subtract unit with borrow out.
// Depends on iglu_pkg for the request and response structs.
module iglu_alu (
	input  iglu_pkg::alu_req_t req,
	output iglu_pkg::alu_rsp_t rsp
);
	import iglu_pkg::*;

	logic [W:0] full;
	word_t      opb_x;

	assign opb_x = req.sub ? ~req.opb : req.opb;
	assign full  = {1'b0, req.opa} + {1'b0, opb_x} + {{W{1'b0}}, req.sub};

	assign rsp.sum    = full[W-1:0];
	// subtract: no carry out means opa < opb
	assign rsp.borrow = req.sub & ~full[W];

endmodule

>>> design/integer_gcd_lcm_unit_core.sv
`timescale 1ns / 1ps
// Integer gcd / lcm unit: binary gcd, restoring divide and shift-add multiply on one adder.
// gcd runs negate, init, removal of common factors of two and the reduction loop; lcm then
// adds a restoring divide, a quotient negate and a shift-add multiply unless the gcd is zero.
// One request at a time: busy is high from acceptance until the done strobe cycle.
// done is high for one cycle; result holds to the next done; the receiver cannot stall.
// arst_n clears state and done. Depends on iglu_pkg and iglu_alu.
module integer_gcd_lcm_unit_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  logic          mode,
	input  iglu_pkg::word_t a,
	input  iglu_pkg::word_t b,
	output logic          done,
	output iglu_pkg::word_t result
);
	import iglu_pkg::*;

	localparam cnt_t CNT_LAST = CW'(W - 1);

	state_t   state_q, state_d;
	logic     mode_q;
	word_t    a_q, b_q;
	word_t    u_q, v_q, ma_q, g_q;
	cnt_t     k_q;
	logic     done_q;
	word_t    result_q;

	alu_req_t alu_req;
	alu_rsp_t alu_rsp;
	word_t    g_comb;
	word_t    trial;
	logic     done_set;
	word_t    result_nxt;
	logic     u_zero, v_zero, both_even;

	iglu_alu u_alu (
		.req(alu_req),
		.rsp(alu_rsp)
	);

	assign g_comb    = v_q << k_q;
	assign trial     = {u_q[W-2:0], ma_q[W-1]};
	assign u_zero    = (u_q == '0);
	assign v_zero    = (v_q == '0);
	assign both_even = ~u_q[0] & ~v_q[0];

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (start) state_d = S_NEGA;
			S_NEGA: state_d = S_NEGB;
			S_NEGB: state_d = S_INIT;
			S_INIT: state_d = S_TWOS;
			S_TWOS: begin
				if (u_zero) state_d = S_FIN;
				else if (!both_even) state_d = S_LOOP;
			end
			S_LOOP: if (u_zero) state_d = S_FIN;
			S_FIN: begin
				if (!mode_q || v_zero) state_d = S_IDLE;
				else state_d = S_DIV;
			end
			S_DIV:  if (k_q == CNT_LAST) state_d = S_QNEG;
			S_QNEG: state_d = S_MUL;
			S_MUL:  if (k_q == CNT_LAST) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// outputs: adder operands and result strobe
	always_comb begin
		alu_req.opa = u_q;
		alu_req.opb = v_q;
		alu_req.sub = 1'b1;
		done_set    = 1'b0;
		result_nxt  = u_q;
		case (state_q)
			S_NEGA: begin
				alu_req.opa = '0;
				alu_req.opb = a_q;
			end
			S_NEGB: begin
				alu_req.opa = '0;
				alu_req.opb = b_q;
			end
			S_FIN: begin
				done_set   = ~mode_q | v_zero;
				result_nxt = mode_q ? '0 : g_comb;
			end
			S_DIV: begin
				alu_req.opa = trial;
				alu_req.opb = g_q;
			end
			S_QNEG: begin
				alu_req.opa = '0;
				alu_req.opb = ma_q;
			end
			S_MUL: begin
				alu_req.sub = 1'b0;
				done_set    = (k_q == CNT_LAST);
				result_nxt  = ma_q[0] ? alu_rsp.sum : u_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_set;
		end
	end

	always_ff @(posedge clk) begin
		if (done_set) result_q <= result_nxt;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					mode_q <= mode;
					a_q    <= a;
					b_q    <= b;
				end
			end
			S_NEGA: begin
				ma_q <= a_q[W-1] ? alu_rsp.sum : a_q;
				u_q  <= a_q[W-1] ? alu_rsp.sum : a_q;
			end
			S_NEGB: begin
				v_q <= b_q[W-1] ? alu_rsp.sum : b_q;
				k_q <= '0;
			end
			S_INIT: begin
				// a zero second operand: move the first one over so the loop ends at once
				if (v_zero) begin
					u_q <= '0;
					v_q <= u_q;
				end
			end
			S_TWOS: begin
				if (!u_zero && both_even) begin
					u_q <= u_q >> 1;
					v_q <= v_q >> 1;
					k_q <= k_q + 1'b1;
				end
			end
			S_LOOP: begin
				if (!u_zero) begin
					if (!u_q[0]) begin
						u_q <= u_q >> 1;
					end else if (!v_q[0]) begin
						v_q <= v_q >> 1;
					end else if (alu_rsp.borrow) begin
						// keep u the larger one
						u_q <= v_q;
						v_q <= u_q;
					end else begin
						u_q <= alu_rsp.sum >> 1;
					end
				end
			end
			S_FIN: begin
				g_q <= g_comb;
				u_q <= '0;
				k_q <= '0;
			end
			S_DIV: begin
				u_q  <= alu_rsp.borrow ? trial : alu_rsp.sum;
				ma_q <= {ma_q[W-2:0], ~alu_rsp.borrow};
				k_q  <= k_q + 1'b1;
			end
			S_QNEG: begin
				if (a_q[W-1]) ma_q <= alu_rsp.sum;
				u_q <= '0;
				v_q <= b_q;
				k_q <= '0;
			end
			S_MUL: begin
				if (ma_q[0]) u_q <= alu_rsp.sum;
				v_q  <= v_q << 1;
				ma_q <= ma_q >> 1;
				k_q  <= k_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("done without a request in flight");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while still busy");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted request did not raise busy");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (g_q != '0))
		else $error("divide entered with zero gcd");

endmodule
